// File: sv/sfo_pkg.sv
// shared types and constants for the stereo linear fade-out unit
package sfo_pkg;

    localparam int CNT_W  = 32;
    localparam int SMP_W  = 16;
    localparam int QUOT_W = 8;
    localparam int GAIN_W = QUOT_W + 1;
    localparam int STEP_W = $clog2(QUOT_W);
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(256);
    localparam logic [CNT_W-1:0]  CFG_RESET = '1;

    typedef enum logic [0:0] {
        REG_FADE_START = 1'b0,
        REG_FADE_END   = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_FADE,
        MODE_SILENT
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL_L,
        ST_MUL_R,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] fade_start;
        logic [CNT_W-1:0] fade_end;
    } t_fade_cfg;

    typedef struct packed {
        logic               start;
        logic [CNT_W-1:0]   num;
        logic [CNT_W-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [QUOT_W-1:0]  quot;
    } t_div_rsp;

endpackage

// File: sv/sfo_if.sv
// request channels for sample pairs in and faded pairs out
interface sfo_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [sfo_pkg::SMP_W-1:0]   left_in;
    logic signed [sfo_pkg::SMP_W-1:0]   right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sfo_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [sfo_pkg::SMP_W-1:0]   left_out;
    logic signed [sfo_pkg::SMP_W-1:0]   right_out;
    logic                               song_done;

    modport source (output valid, output left_out, output right_out,
                    output song_done, input ready);
    modport sink   (input valid, input left_out, input right_out,
                    input song_done, output ready);
endinterface

// File: sv/stereo_linear_fade_out_unit.sv
// top level of the stereo linear fade-out unit
// One stereo pair is taken per request and one faded pair returned. A pair
// before fade_start or at/after fade_end passes the check state and then loads
// the output register once it is free; a pair inside the fade goes from the
// check state through the 8-step divider forming the gain and the single
// multiplier that scales left then right before it loads there. After the output
// register loads, the unit returns to idle and can accept the next pair. The input is not ready while
// a pair is in work; the output register lets the next pair enter while a
// result waits. Registers: fade_start at address 0, fade_end at address 4,
// both reset to all ones.
module stereo_linear_fade_out_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    sfo_in_if.sink                      i_in,
    sfo_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sfo_pkg::ADDR_W-1:0]  paddr,
    input  logic [sfo_pkg::DATA_W-1:0]  pwdata,
    output logic [sfo_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    sfo_pkg::t_fade_cfg                 w_cfg;
    sfo_pkg::t_state                    r_state, n_state;
    sfo_pkg::t_mode                     r_mode, w_mode;
    sfo_pkg::t_div_req                  w_div_req;
    sfo_pkg::t_div_rsp                  w_div_rsp;

    logic [sfo_pkg::CNT_W-1:0]          r_count;
    logic signed [sfo_pkg::SMP_W-1:0]   r_left, r_right, r_res_l;
    logic signed [sfo_pkg::SMP_W-1:0]   w_mul_in, w_mul_out;
    logic [sfo_pkg::GAIN_W-1:0]         w_gain;

    logic                               r_out_valid;
    logic signed [sfo_pkg::SMP_W-1:0]   r_out_left, r_out_right;
    logic                               r_out_done;

    logic                               w_in_ready;
    logic                               w_div_start;
    logic                               w_sel_left;
    logic                               w_out_load;

    sfo_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_div_req.start = w_div_start;
    assign w_div_req.num   = r_count - w_cfg.fade_start;
    assign w_div_req.den   = w_cfg.fade_end - w_cfg.fade_start;

    sfo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_gain   = sfo_pkg::GAIN_ONE - {1'b0, w_div_rsp.quot};
    assign w_mul_in = w_sel_left ? r_left : r_right;

    sfo_mul u_mul (
        .i_clk    (i_clk),
        .i_sample (w_mul_in),
        .i_gain   (w_gain),
        .o_prod   (w_mul_out)
    );

    always_comb begin
        if (r_count < w_cfg.fade_start) begin
            w_mode = sfo_pkg::MODE_PASS;
        end else if (r_count >= w_cfg.fade_end) begin
            w_mode = sfo_pkg::MODE_SILENT;
        end else begin
            w_mode = sfo_pkg::MODE_FADE;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sfo_pkg::ST_IDLE: begin
                if (i_in.valid) n_state = sfo_pkg::ST_CHECK;
            end
            sfo_pkg::ST_CHECK: begin
                n_state = (w_mode == sfo_pkg::MODE_FADE) ? sfo_pkg::ST_DIV : sfo_pkg::ST_OUT;
            end
            sfo_pkg::ST_DIV: begin
                if (w_div_rsp.done) n_state = sfo_pkg::ST_MUL_L;
            end
            sfo_pkg::ST_MUL_L: n_state = sfo_pkg::ST_MUL_R;
            sfo_pkg::ST_MUL_R: n_state = sfo_pkg::ST_OUT;
            sfo_pkg::ST_OUT: begin
                if (!r_out_valid || o_out.ready) n_state = sfo_pkg::ST_IDLE;
            end
            default: n_state = sfo_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_sel_left  = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            sfo_pkg::ST_IDLE:  w_in_ready  = 1'b1;
            sfo_pkg::ST_CHECK: w_div_start = (w_mode == sfo_pkg::MODE_FADE);
            sfo_pkg::ST_DIV:   w_sel_left  = 1'b1;
            sfo_pkg::ST_MUL_L: w_sel_left  = 1'b1;
            sfo_pkg::ST_MUL_R: ;
            sfo_pkg::ST_OUT:   w_out_load  = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sfo_pkg::ST_IDLE;
            r_mode      <= sfo_pkg::MODE_PASS;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == sfo_pkg::ST_CHECK) r_mode <= w_mode;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                if (r_mode != sfo_pkg::MODE_SILENT) r_count <= r_count + 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_left  <= i_in.left_in;
            r_right <= i_in.right_in;
        end
        if (r_state == sfo_pkg::ST_MUL_R) r_res_l <= w_mul_out;
        if (w_out_load) begin
            case (r_mode)
                sfo_pkg::MODE_FADE: begin
                    r_out_left  <= r_res_l;
                    r_out_right <= w_mul_out;
                    r_out_done  <= 1'b0;
                end
                sfo_pkg::MODE_SILENT: begin
                    r_out_left  <= '0;
                    r_out_right <= '0;
                    r_out_done  <= 1'b1;
                end
                default: begin
                    r_out_left  <= r_left;
                    r_out_right <= r_right;
                    r_out_done  <= 1'b0;
                end
            endcase
        end
    end

    assign i_in.ready      = w_in_ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.left_out  = r_out_left;
    assign o_out.right_out = r_out_right;
    assign o_out.song_done = r_out_done;

endmodule

// File: sv/sfo_apb.sv
// apb register file holding fade start and fade end
module sfo_apb (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sfo_pkg::ADDR_W-1:0]  paddr,
    input  logic [sfo_pkg::DATA_W-1:0]  pwdata,
    output logic [sfo_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output sfo_pkg::t_fade_cfg          o_cfg
);

    sfo_pkg::t_fade_cfg r_cfg;
    sfo_pkg::t_reg_idx  w_idx;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_idx  = sfo_pkg::t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fade_start <= sfo_pkg::CFG_RESET;
            r_cfg.fade_end   <= sfo_pkg::CFG_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                sfo_pkg::REG_FADE_START: r_cfg.fade_start <= pwdata;
                sfo_pkg::REG_FADE_END:   r_cfg.fade_end   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            sfo_pkg::REG_FADE_START: prdata = r_cfg.fade_start;
            sfo_pkg::REG_FADE_END:   prdata = r_cfg.fade_end;
            default:                 prdata = '0;
        endcase
    end

endmodule

// File: sv/sfo_div.sv
// restoring divider, one quotient bit per cycle, quotient known below 2^QUOT_W
module sfo_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sfo_pkg::t_div_req   i_req,
    output sfo_pkg::t_div_rsp   o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [sfo_pkg::STEP_W-1:0]     r_step;
    logic [sfo_pkg::CNT_W-1:0]      r_rem;
    logic [sfo_pkg::CNT_W-1:0]      r_den;
    logic [sfo_pkg::QUOT_W-1:0]     r_quot;
    logic [sfo_pkg::CNT_W:0]        w_shift;
    logic                           w_ge;

    // remainder stays below the divisor, so the shifted value fits in one more bit
    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == sfo_pkg::STEP_W'(sfo_pkg::QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.num;
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? sfo_pkg::CNT_W'(w_shift - {1'b0, r_den})
                           : w_shift[sfo_pkg::CNT_W-1:0];
            r_quot <= {r_quot[sfo_pkg::QUOT_W-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// File: sv/sfo_mul.sv
// registered gain multiplier with arithmetic shift by 8, shared by both channels
module sfo_mul (
    input  logic                                i_clk,
    input  logic signed [sfo_pkg::SMP_W-1:0]    i_sample,
    input  logic        [sfo_pkg::GAIN_W-1:0]   i_gain,
    output logic signed [sfo_pkg::SMP_W-1:0]    o_prod
);

    localparam int PROD_W = sfo_pkg::SMP_W + sfo_pkg::GAIN_W + 1;

    logic signed [PROD_W-1:0]           w_prod;
    logic signed [sfo_pkg::SMP_W-1:0]   r_prod;

    assign w_prod = i_sample * $signed({1'b0, i_gain});

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod[sfo_pkg::SMP_W+7:8];
    end

    assign o_prod = r_prod;

endmodule
